@@ rtl/cpbf_pkg.sv @@
// Shared constants, types and result structure for the closest-pair unit.
// No dependencies.
package cpbf_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 16;

	localparam int FIELD_W = 16;
	localparam int IDX_W   = 10;
	localparam int DIST_W  = 33;

	localparam int ADDR_W  = $clog2(MAX_POINTS);
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int ENTRY_W = 2 * COORD_BITS;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int SUM_W   = SQ_W + 1;
	localparam int BEST_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ADDR_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [ENTRY_W-1:0]    entry_t;
	typedef logic [SQ_W-1:0]       sq_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [BEST_W-1:0]     best_t;

	localparam best_t BEST_INIT = BEST_W'({DIST_W{1'b1}});

	typedef struct packed {
		logic valid;
		logic busy;
		idx_t idx;
		sum_t sq_sum;
	} dist_res_t;

endpackage

@@ rtl/cpbf_if.sv @@
// Point and result channel interfaces, valid/ready handshake.
// Depends on cpbf_pkg for field widths.
interface cpbf_pt_if;
	logic                          valid;
	logic                          ready;
	logic [cpbf_pkg::FIELD_W-1:0]  point_x;
	logic [cpbf_pkg::FIELD_W-1:0]  point_y;
	logic                          last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

interface cpbf_res_if;
	logic                         valid;
	logic                         ready;
	logic [cpbf_pkg::IDX_W-1:0]   later_index;
	logic [cpbf_pkg::IDX_W-1:0]   earlier_index;
	logic [cpbf_pkg::DIST_W-1:0]  min_sq_distance;
	logic                         pair_valid;
	logic                         overflowed;

	modport source (output valid, output later_index, output earlier_index,
		output min_sq_distance, output pair_valid, output overflowed, input ready);
	modport sink (input valid, input later_index, input earlier_index,
		input min_sq_distance, input pair_valid, input overflowed, output ready);
endinterface

@@ rtl/cpbf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cpbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/cpbf_dist.sv @@
// Squared-distance pipeline: absolute differences, squares, sum.
// Depends on cpbf_pkg.
module cpbf_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  cpbf_pkg::idx_t      idx,
	input  cpbf_pkg::entry_t    entry,
	input  cpbf_pkg::coord_t    px,
	input  cpbf_pkg::coord_t    py,
	output cpbf_pkg::dist_res_t res
);
	import cpbf_pkg::*;

	coord_t ex, ey, dx, dy;
	logic   v_s2, v_s3;
	idx_t   idx_s2, idx_s3;
	coord_t dx_s2, dy_s2;
	sq_t    sqx_s3, sqy_s3;

	assign ex = entry[COORD_BITS-1:0];
	assign ey = entry[ENTRY_W-1:COORD_BITS];
	assign dx = (px >= ex) ? px - ex : ex - px;
	assign dy = (py >= ey) ? py - ey : ey - py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx;
		dx_s2  <= dx;
		dy_s2  <= dy;
		idx_s3 <= idx_s2;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	assign res.valid  = v_s3;
	assign res.busy   = v_s2 || v_s3;
	assign res.idx    = idx_s3;
	assign res.sq_sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
endmodule

@@ rtl/closest_pair_brute_force_unit.sv @@
// Brute-force closest pair of 2-D points, Q0.16 coordinates.
// Depends on cpbf_pkg, cpbf_if, cpbf_ram and cpbf_dist.
// Point beats arrive on pt; a beat with last_point set closes the set and
// one result beat follows on res with the closest pair's indices, their
// squared distance, pair_valid (two or more points stored) and overflowed
// (points past the 1024-entry store were dropped).
// Each point is written to the point memory as it is taken, then every
// earlier point is read back, one per cycle through the single read port,
// and run through a three-stage distance pipeline feeding the minimum
// compare. The next point is taken only once that scan has drained the
// pipeline; pt.ready is high only between points. A dropped point skips
// the scan. The result beat is registered from the FIN state after the
// last point's scan, or with no scan at all if that point is dropped.
// The result sits in an output register; new points are taken while it
// waits. If a second set closes before res.ready takes the first result,
// the block holds until the register frees.
// Reset clears the count, the running minimum and the output register;
// the memory needs no clearing since only written entries are read.
module closest_pair_brute_force_unit (
	input  logic        clk,
	input  logic        arst_n,
	cpbf_pt_if.sink     pt,
	cpbf_res_if.source  res
);
	import cpbf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	cnt_t       cnt_q, cur_q, k_q;
	coord_t     px_q, py_q;
	logic       last_q, ovf_q;
	best_t      best_q;
	idx_t       later_q, earlier_q;
	logic       v_s1;
	idx_t       idx_s1;
	entry_t     rdata;
	dist_res_t  dres;

	logic                out_v_q;
	logic [IDX_W-1:0]    out_later_q, out_earlier_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_pair_q, out_ovf_q;

	logic in_acc, room, wr_en, rd_en, scan_done, out_free, emit;

	assign pt.ready  = (state_q == ST_IDLE);
	assign in_acc    = pt.valid && pt.ready;
	assign room      = (cnt_q != CNT_W'(MAX_POINTS));
	assign wr_en     = in_acc && room;
	assign rd_en     = (state_q == ST_SCAN) && (k_q != cur_q);
	assign scan_done = (state_q == ST_SCAN) && (k_q == cur_q) && !v_s1 && !dres.busy;
	assign out_free  = !out_v_q || res.ready;
	assign emit      = (state_q == ST_FIN) && last_q && out_free;

	cpbf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata ({COORD_BITS'(pt.point_y), COORD_BITS'(pt.point_x)}),
		.re    (rd_en),
		.raddr (k_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	cpbf_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (v_s1),
		.idx    (idx_s1),
		.entry  (rdata),
		.px     (px_q),
		.py     (py_q),
		.res    (dres)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= k_q[ADDR_W-1:0];
		end
		if (in_acc) begin
			px_q <= COORD_BITS'(pt.point_x);
			py_q <= COORD_BITS'(pt.point_y);
		end
		if (emit) begin
			out_later_q   <= (cnt_q >= CNT_W'(2)) ? IDX_W'(later_q) : '0;
			out_earlier_q <= (cnt_q >= CNT_W'(2)) ? IDX_W'(earlier_q) : '0;
			out_dist_q    <= (cnt_q >= CNT_W'(2)) ? DIST_W'(best_q) : '0;
			out_pair_q    <= (cnt_q >= CNT_W'(2));
			out_ovf_q     <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			cur_q     <= '0;
			k_q       <= '0;
			last_q    <= 1'b0;
			ovf_q     <= 1'b0;
			best_q    <= BEST_INIT;
			later_q   <= '0;
			earlier_q <= '0;
			v_s1      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			v_s1 <= rd_en;
			if (rd_en) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (dres.valid && (BEST_W'(dres.sq_sum) < best_q)) begin
				best_q    <= BEST_W'(dres.sq_sum);
				later_q   <= cur_q[ADDR_W-1:0];
				earlier_q <= dres.idx;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= pt.last_point;
						k_q    <= '0;
						cur_q  <= cnt_q;
						if (room) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= ST_SCAN;
						end else begin
							ovf_q   <= 1'b1;
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						cnt_q     <= '0;
						best_q    <= BEST_INIT;
						later_q   <= '0;
						earlier_q <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid           = out_v_q;
	assign res.later_index     = out_later_q;
	assign res.earlier_index   = out_earlier_q;
	assign res.min_sq_distance = out_dist_q;
	assign res.pair_valid      = out_pair_q;
	assign res.overflowed      = out_ovf_q;
endmodule
